[hw/rtl/stc_pkg.sv]
// Shared types and constants for the stable counting sort core.
// Used by stc_cell and stable_counting_sort_core; no dependencies.
package stc_pkg;

	localparam int KEY_W     = 8;
	localparam int MAX_ITEMS = 64;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		key_t key;
		logic last;
	} in_t;

	typedef struct packed {
		key_t value;
		logic last_res;
	} out_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic insert;
		logic shift;
		key_t key;
	} cell_ctl_t;

	// What one cell shows its neighbours.
	typedef struct packed {
		logic valid;
		logic gt;
		key_t key;
	} cell_link_t;

	function automatic key_t clamp_key(input key_t k, input key_t lim);
		return (k > lim) ? lim : k;
	endfunction

endpackage

[hw/rtl/stc_cell.sv]
// One cell of the sorting chain: holds a single key and its valid bit.
// Depends on stc_pkg for the control and link types.
module stc_cell
	import stc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  cell_link_t left,
	input  cell_link_t right,
	output cell_link_t link
);

	logic valid_q;
	key_t key_q;
	logic valid_d;
	key_t key_d;
	logic gt;

	assign gt = valid_q && (key_q > ctl.key);

	assign link.valid = valid_q;
	assign link.gt    = gt;
	assign link.key   = key_q;

	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		if (ctl.shift) begin
			// advance the chain towards the output end
			valid_d = right.valid;
			key_d   = right.key;
		end else if (ctl.insert && (gt || !valid_q)) begin
			if (left.gt) begin
				valid_d = 1'b1;
				key_d   = left.key;
			end else if (left.valid) begin
				valid_d = 1'b1;
				key_d   = ctl.key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

[hw/rtl/stable_counting_sort_core.sv]
// Stable counting sort core: a chain of MAX_ITEMS insertion cells and the load/emit control.
// Depends on stc_pkg and stc_cell.
//
// Keys load one per cycle: each accepted item is placed in order in the cell chain in the
// cycle it arrives, so busy stays low while a set is loading. The item marked last is placed
// too and starts the output: busy then goes high while the chain shifts the n keys held (1
// to MAX_ITEMS) onto result, one sorted key per cycle, ascending, with done high. Results
// cannot be held off; a receiver must take each on its done cycle. Keys beyond MAX_ITEMS in
// one set are dropped. max_key may be written only while idle.
module stable_counting_sort_core
	import stc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	output logic busy,
	input  logic cfg_we,
	input  key_t cfg_data,
	output logic done,
	output out_t result
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic       state_q;
	cnt_t       cnt_q;
	key_t       max_key_q;
	logic       accept;
	logic       room;
	logic       ins;
	cell_ctl_t  ctl;
	cell_link_t links [MAX_ITEMS];
	cell_link_t lefts [MAX_ITEMS];
	cell_link_t rights[MAX_ITEMS];

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;
	assign room   = (cnt_q < cnt_t'(MAX_ITEMS));
	assign ins    = accept && room;

	assign ctl.insert = ins;
	assign ctl.shift  = (state_q == ST_EMIT);
	assign ctl.key    = clamp_key(item.key, max_key_q);

	always_comb begin
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (i == 0) begin
				lefts[i] = '{valid: 1'b1, gt: 1'b0, key: '0};
			end else begin
				lefts[i] = links[i-1];
			end
			if (i == MAX_ITEMS - 1) begin
				rights[i] = '{valid: 1'b0, gt: 1'b0, key: '0};
			end else begin
				rights[i] = links[i+1];
			end
		end
	end

	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		stc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.left  (lefts[g]),
			.right (rights[g]),
			.link  (links[g])
		);
	end

	assign done            = (state_q == ST_EMIT);
	assign result.value    = links[0].key;
	assign result.last_res = (cnt_q == cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			max_key_q <= '1;
		end else begin
			if (cfg_we) begin
				max_key_q <= cfg_data;
			end
			case (state_q)
				ST_LOAD: begin
					if (ins) begin
						cnt_q <= cnt_q + cnt_t'(1);
					end
					if (accept && item.last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// count down the keys still in the chain
					cnt_q <= cnt_q - cnt_t'(1);
					if (cnt_q == cnt_t'(1)) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_last_ends_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last_res |=> !busy)
		else $error("emission did not end after the final item");

	a_last_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.last |=> done)
		else $error("last item did not start emission");

	a_emit_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> links[0].valid)
		else $error("emitting from an empty cell");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(MAX_ITEMS))
		else $error("key count beyond chain length");

endmodule

[verif/tb_stable_counting_sort_core.sv]
// Self-checking testbench for stable_counting_sort_core: sets of keys go in, and each sorted
// result is checked against a histogram predictor kept in the bench.
// Depends on stc_pkg and the core RTL only.
module tb_stable_counting_sort_core;
	import stc_pkg::*;

	localparam int NBINS          = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * MAX_ITEMS + 16;
	localparam int PHASE_ITEMS    = 8;

	logic clk;
	logic arst_n;
	logic start;
	in_t  item;
	logic busy;
	logic cfg_we;
	key_t cfg_data;
	logic done;
	out_t result;

	stable_counting_sort_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

	in_t        pending_items[$];
	out_t       sorted_q[$];
	logic [6:0] key_hist[NBINS];
	logic [6:0] keys_held;
	key_t       sat_limit;

	bit took;
	bit no_idle;
	int gap_left;
	int mismatches;
	int items_in;
	int results_out;
	int sets_done;
	int cfg_writes;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void flag_mismatch(string what, int exp_v, int got_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
		end
	endfunction

	// Count one key; on the last of a set, emit the whole histogram in ascending order.
	function automatic void count_key(in_t it);
		key_t bin;
		int   total;
		int   emitted;
		out_t r;
		if (keys_held < MAX_ITEMS) begin
			bin = (it.key > sat_limit) ? sat_limit : it.key;
			key_hist[bin] = key_hist[bin] + 7'd1;
			keys_held = keys_held + 7'd1;
		end
		if (it.last) begin
			total = keys_held;
			emitted = 0;
			for (int b = 0; b < NBINS; b++) begin
				for (int c = 0; c < key_hist[b] && emitted < total; c++) begin
					r.value = key_t'(b);
					r.last_res = (emitted + 1 == total);
					sorted_q.push_back(r);
					emitted++;
				end
				key_hist[b] = '0;
			end
			keys_held = '0;
			sets_done++;
		end
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// Monitor: predict on each accepted item, check each result strobe, run the watchdog.
	always @(posedge clk) begin
		out_t exp_r;
		bit   progress;
		progress = 1'b0;
		if (!arst_n) begin
			took = 1'b0;
			for (int b = 0; b < NBINS; b++) key_hist[b] = '0;
			keys_held = '0;
			sat_limit = 8'd255;
			idle_cycles = 0;
		end else begin
			if (cfg_we) begin
				sat_limit = cfg_data;
				cfg_writes++;
			end
			took = start && !busy;
			if (took) begin
				count_key(item);
				items_in++;
			end
			if (done) begin
				results_out++;
				if (sorted_q.size() == 0) begin
					flag_mismatch("unexpected result, value", -1, result.value);
				end else begin
					progress = 1'b1;
					exp_r = sorted_q.pop_front();
					if (result.value !== exp_r.value)
						flag_mismatch("value", exp_r.value, result.value);
					if (result.last_res !== exp_r.last_res)
						flag_mismatch("last_res", exp_r.last_res, result.last_res);
				end
			end
			// a stray result strobe is no progress
			if (took || progress || cfg_we) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired: %0d results still outstanding", sorted_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Driver: hold an item until taken, then idle for a random gap before the next.
	always @(negedge clk) begin
		in_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// hold
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending_items.size() > 0) begin
			nxt = pending_items.pop_front();
			item <= nxt;
			start <= 1'b1;
			if (nxt.last) no_idle = ($urandom_range(0, 3) == 0);
			gap_left = draw_gap();
		end else begin
			start <= 1'b0;
		end
	end

	task automatic add_key(key_t k, bit is_last);
		in_t it;
		it.key = k;
		it.last = is_last;
		pending_items.push_back(it);
	endtask

	// Keys near the limit, small keys with many repeats, or anything at all.
	task automatic add_random_set(int len, key_t lim);
		int   r;
		key_t k;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (r < 4) k = $urandom_range(0, 255);
			else if (r < 7) k = $urandom_range(0, 7);
			else k = $urandom_range((lim > 4) ? lim - 4 : 0, (lim < 251) ? lim + 4 : 255);
			add_key(k, i == len - 1);
		end
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || start || sorted_q.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_key(key_t v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		key_t lim;
		int   phase_count;
		int   len;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		gap_left = 0;
		no_idle = 1'b0;
		mismatches = 0;
		items_in = 0;
		results_out = 0;
		sets_done = 0;
		cfg_writes = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-key sets at both ends, duplicates, alternating bit patterns
		add_key(8'h00, 1'b1);
		add_key(8'hFF, 1'b1);
		add_key(8'hAA, 1'b0);
		add_key(8'h55, 1'b0);
		add_key(8'hAA, 1'b0);
		add_key(8'hFF, 1'b0);
		add_key(8'h00, 1'b0);
		add_key(8'h55, 1'b1);
		add_key(8'h01, 1'b0);
		add_key(8'h80, 1'b0);
		add_key(8'h7F, 1'b0);
		add_key(8'hFE, 1'b1);
		wait_idle();

		// limit of zero: everything collapses onto bin zero
		write_max_key(8'd0);
		add_key(8'd0, 1'b0);
		add_key(8'd200, 1'b0);
		add_key(8'hFF, 1'b1);
		wait_idle();

		write_max_key(8'd100);
		add_key(8'd100, 1'b0);
		add_key(8'd101, 1'b0);
		add_key(8'd3, 1'b0);
		add_key(8'hFF, 1'b1);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: lim = 8'd255;
				1: lim = 8'd254;
				2: lim = 8'd1;
				default: lim = $urandom_range(0, 255);
			endcase
			write_max_key(lim);
			phase_count = 0;
			// a full set exactly at capacity, and one that overflows with the last three keys dropped
			if (p == 1) begin
				add_random_set(MAX_ITEMS, lim);
				phase_count += MAX_ITEMS;
			end
			if (p == 3) begin
				add_random_set(MAX_ITEMS + 3, lim);
				phase_count += MAX_ITEMS + 3;
			end
			while (phase_count < PHASE_ITEMS + ((p == 1 || p == 3) ? MAX_ITEMS : 0)) begin
				len = $urandom_range(1, 12);
				add_random_set(len, lim);
				phase_count += len;
			end
			wait_idle();
		end

		$display("Sent %0d keys in %0d sets over %0d limit settings; checked %0d sorted results.",
			items_in, sets_done, cfg_writes + 1, results_out);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
